// File: src/table_linear_interpolator_assert.svh
// assertion helpers shared by the interpolator modules
`ifndef TABLE_LINEAR_INTERPOLATOR_ASSERT_SVH
`define TABLE_LINEAR_INTERPOLATOR_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define TLI_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent must hold in the cycle after the antecedent
`define TLI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/tli_pkg.sv
package tli_pkg;

   localparam int MAX_POINTS_DEF = 64;

   localparam logic [1:0] STS_OK  = 2'd0;
   localparam logic [1:0] STS_FEW = 2'd1;
   localparam logic [1:0] STS_SAT = 2'd2;

   localparam logic [5:0] MUL_LAST = 6'd3;
   localparam logic [5:0] DIV_LAST = 6'd33;

   typedef enum logic [4:0] {
      ST_IDLE, ST_CHECK, ST_ASC0, ST_ASC1, ST_HDIR, ST_HUP, ST_HUP_EV, ST_HDN,
      ST_HDN_EV, ST_BIS, ST_BIS_EV, ST_SEG, ST_RDJ, ST_RDJ1, ST_DIFF, ST_MUL,
      ST_DIVI, ST_DIV, ST_OUT, ST_FEW
   } state_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_ACCEPT, OP_RD_FIRST, OP_RD_LAST, OP_START, OP_HUNT_DIR, OP_HUP,
      OP_HUP_EV, OP_HDN, OP_HDN_EV, OP_BIS, OP_BIS_EV, OP_SEG, OP_RD_J, OP_RD_J1,
      OP_DIFF, OP_MUL, OP_DIV_INIT, OP_DIV, OP_OUT, OP_OUT_FEW
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic n_small;
      logic hunt_ok;
      logic above;
      logic up_end;
      logic dn_end;
      logic bis_done;
      logic zero_w;
      logic step_last;
      logic out_free;
   } sts_type;

   // floor of the fourth root, at least 1, for counts below 128
   function automatic logic [1:0] window_f(input logic [6:0] n);
      logic [1:0] r;
      if (n >= 7'd81) begin
         r = 2'd3;
      end else if (n >= 7'd16) begin
         r = 2'd2;
      end else begin
         r = 2'd1;
      end
      return r;
   endfunction

endpackage

// File: src/tli_ctrl.sv
module tli_ctrl
   import tli_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_mode,
   output logic    req_stall,
   input  sts_type sts,
   output cmd_type cmd
);

`include "table_linear_interpolator_assert.svh"

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_valid && req_mode) state_in = ST_CHECK;
         ST_CHECK:  state_in = sts.n_small ? ST_FEW : ST_ASC0;
         ST_ASC0:   state_in = ST_ASC1;
         ST_ASC1:   state_in = sts.hunt_ok ? ST_HDIR : ST_BIS;
         ST_HDIR:   state_in = sts.above ? ST_HUP : ST_HDN;
         ST_HUP:    state_in = sts.up_end ? ST_BIS : ST_HUP_EV;
         ST_HUP_EV: state_in = sts.above ? ST_HUP : ST_BIS;
         ST_HDN:    state_in = sts.dn_end ? ST_BIS : ST_HDN_EV;
         ST_HDN_EV: state_in = sts.above ? ST_BIS : ST_HDN;
         ST_BIS:    state_in = sts.bis_done ? ST_SEG : ST_BIS_EV;
         ST_BIS_EV: state_in = ST_BIS;
         ST_SEG:    state_in = ST_RDJ;
         ST_RDJ:    state_in = ST_RDJ1;
         ST_RDJ1:   state_in = ST_DIFF;
         ST_DIFF:   state_in = sts.zero_w ? ST_OUT : ST_MUL;
         ST_MUL:    state_in = sts.step_last ? ST_DIVI : ST_MUL;
         ST_DIVI:   state_in = ST_DIV;
         ST_DIV:    state_in = sts.step_last ? ST_OUT : ST_DIV;
         ST_OUT:    if (sts.out_free) state_in = ST_IDLE;
         ST_FEW:    if (sts.out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall = (state_ff != ST_IDLE);
      cmd.op = OP_NONE;
      unique case (state_ff)
         ST_IDLE:   cmd.op = req_valid ? OP_ACCEPT : OP_NONE;
         ST_CHECK:  cmd.op = OP_RD_FIRST;
         ST_ASC0:   cmd.op = OP_RD_LAST;
         ST_ASC1:   cmd.op = OP_START;
         ST_HDIR:   cmd.op = OP_HUNT_DIR;
         ST_HUP:    cmd.op = OP_HUP;
         ST_HUP_EV: cmd.op = OP_HUP_EV;
         ST_HDN:    cmd.op = OP_HDN;
         ST_HDN_EV: cmd.op = OP_HDN_EV;
         ST_BIS:    cmd.op = OP_BIS;
         ST_BIS_EV: cmd.op = OP_BIS_EV;
         ST_SEG:    cmd.op = OP_SEG;
         ST_RDJ:    cmd.op = OP_RD_J;
         ST_RDJ1:   cmd.op = OP_RD_J1;
         ST_DIFF:   cmd.op = OP_DIFF;
         ST_MUL:    cmd.op = OP_MUL;
         ST_DIVI:   cmd.op = OP_DIV_INIT;
         ST_DIV:    cmd.op = OP_DIV;
         ST_OUT:    cmd.op = OP_OUT;
         ST_FEW:    cmd.op = OP_OUT_FEW;
         default:   cmd.op = OP_NONE;
      endcase
   end

   `TLI_ASSERT_NEXT(a_out_done, clock, reset, (state_ff == ST_OUT) && sts.out_free,
      state_ff == ST_IDLE, "result transfer did not return to idle")
   `TLI_ASSERT_NOW(a_busy_stall, clock, reset, state_ff != ST_IDLE && req_valid,
      cmd.op != OP_ACCEPT, "item taken while a query is in progress")

endmodule

// File: src/tli_dpath.sv
module tli_dpath
   import tli_pkg::*;
#(
   parameter int MAX_POINTS = MAX_POINTS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output sts_type            sts,
   input  logic               csr_we,
   input  logic        [6:0]  csr_point_count,
   input  logic               req_mode,
   input  logic        [5:0]  req_point_index,
   input  logic signed [31:0] req_x_value,
   input  logic signed [31:0] req_y_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_result_value,
   output logic        [1:0]  rsp_status
);

`include "table_linear_interpolator_assert.svh"

   localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CW = (IW + 2 > 8) ? IW + 2 : 8;

   logic signed [31:0] x_mem [MAX_POINTS];
   logic signed [31:0] y_mem [MAX_POINTS];
   logic signed [31:0] rdx_ff, rdy_ff;
   logic [IW-1:0]      rd_addr;
   logic               we;

   // control state
   logic [6:0]    point_count_ff, point_count_in;
   logic [IW-1:0] saved_ff, saved_in;
   logic          corr_ff, corr_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // payload state
   logic signed [31:0] x_ff, x_in, x0_ff, x0_in;
   logic               asc_ff, asc_in;
   logic [CW-1:0]      lo_ff, lo_in, hi_ff, hi_in, inc_ff, inc_in, mid_ff, mid_in;
   logic [CW-1:0]      j_ff, j_in;
   logic signed [31:0] xj_ff, xj_in, yj_ff, yj_in, xj1_ff, xj1_in, yj1_ff, yj1_in;
   logic [32:0]        a_ff, a_in, b_ff, b_in, c_ff, c_in;
   logic               neg_ff, neg_in, zero_ff, zero_in, big_ff, big_in;
   logic [65:0]        acc_ff, acc_in;
   logic [5:0]         step_ff, step_in;
   logic [33:0]        rem_ff, rem_in, p_ff, p_in, q_ff, q_in;
   logic signed [31:0] res_ff, res_in;
   logic [1:0]         status_ff, status_in;

   // combinational helpers
   logic [CW-1:0] n_w, nm1, nm2, js_w, up_sum, dn_dif, mid_w, seg_j, js_dist;
   logic [1:0]    dj_w;
   logic          above_w;
   logic [16:0]   a_sel, b_sel;
   logic [33:0]   pp;
   logic [65:0]   pp_sh;
   logic [33:0]   t_w;
   logic          ge_w;
   logic [32:0]   dx33, dxq33, dy33;
   logic signed [35:0] sum36;

   assign n_w = (32'(point_count_ff) > 32'(MAX_POINTS)) ? CW'(MAX_POINTS)
                                                        : CW'(point_count_ff);
   assign nm1     = n_w - CW'(1);
   assign nm2     = n_w - CW'(2);
   assign js_w    = CW'(saved_ff);
   assign dj_w    = window_f(n_w[6:0]);
   assign above_w = (x_ff >= rdx_ff) == asc_ff;
   assign up_sum  = lo_ff + inc_ff;
   assign dn_dif  = lo_ff - inc_ff;
   assign mid_w   = (hi_ff + lo_ff) >> 1;
   assign seg_j   = (lo_ff > nm2) ? nm2 : lo_ff;
   assign js_dist = (lo_ff >= js_w) ? lo_ff - js_w : js_w - lo_ff;

   // partial products, 17 by 17 bits, one per step
   assign a_sel = step_ff[1] ? {1'b0, a_ff[32:17]} : a_ff[16:0];
   assign b_sel = step_ff[0] ? {1'b0, b_ff[32:17]} : b_ff[16:0];
   assign pp    = 34'(a_sel) * 34'(b_sel);
   always_comb begin
      unique case (step_ff[1:0])
         2'd0:    pp_sh = 66'(pp);
         2'd3:    pp_sh = 66'(pp) << 34;
         default: pp_sh = 66'(pp) << 17;
      endcase
   end

   // restoring division, one quotient bit per step
   assign t_w  = {rem_ff[32:0], p_ff[33]};
   assign ge_w = t_w >= {1'b0, c_ff};

   assign dx33  = {xj1_ff[31], xj1_ff} - {xj_ff[31], xj_ff};
   assign dxq33 = {x_ff[31], x_ff} - {xj_ff[31], xj_ff};
   assign dy33  = {yj1_ff[31], yj1_ff} - {yj_ff[31], yj_ff};
   assign sum36 = neg_ff ? 36'(yj_ff) - $signed({2'b00, q_ff})
                         : 36'(yj_ff) + $signed({2'b00, q_ff});

   assign we = (cmd.op == OP_ACCEPT) && !req_mode
               && (32'(req_point_index) < 32'(MAX_POINTS));

   always_comb begin
      sts.n_small   = n_w < CW'(2);
      sts.hunt_ok   = corr_ff && (js_w <= nm1);
      sts.above     = above_w;
      sts.up_end    = up_sum >= nm1;
      sts.dn_end    = lo_ff <= inc_ff;
      sts.bis_done  = (hi_ff - lo_ff) <= CW'(1);
      sts.zero_w    = xj_ff == xj1_ff;
      sts.step_last = step_ff == ((cmd.op == OP_MUL) ? MUL_LAST : DIV_LAST);
      sts.out_free  = !rsp_valid_ff || !rsp_stall;
   end

   always_comb begin
      unique case (cmd.op)
         OP_RD_LAST: rd_addr = IW'(nm1);
         OP_START:   rd_addr = saved_ff;
         OP_HUP:     rd_addr = IW'(up_sum);
         OP_HDN:     rd_addr = IW'(dn_dif);
         OP_BIS:     rd_addr = IW'(mid_w);
         OP_SEG:     rd_addr = IW'(seg_j);
         OP_RD_J:    rd_addr = IW'(j_ff + CW'(1));
         default:    rd_addr = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) begin
         x_mem[IW'(req_point_index)] <= req_x_value;
         y_mem[IW'(req_point_index)] <= req_y_value;
      end
      rdx_ff <= x_mem[rd_addr];
      rdy_ff <= y_mem[rd_addr];
   end

   always_comb begin
      point_count_in = csr_we ? csr_point_count : point_count_ff;
      saved_in = saved_ff;
      corr_in = corr_ff;
      rsp_valid_in = (rsp_valid_ff && rsp_stall) ? 1'b1 : 1'b0;
      x_in = x_ff;  x0_in = x0_ff;  asc_in = asc_ff;
      lo_in = lo_ff;  hi_in = hi_ff;  inc_in = inc_ff;  mid_in = mid_ff;  j_in = j_ff;
      xj_in = xj_ff;  yj_in = yj_ff;  xj1_in = xj1_ff;  yj1_in = yj1_ff;
      a_in = a_ff;  b_in = b_ff;  c_in = c_ff;
      neg_in = neg_ff;  zero_in = zero_ff;  big_in = big_ff;
      acc_in = acc_ff;  step_in = step_ff;  rem_in = rem_ff;  p_in = p_ff;  q_in = q_ff;
      res_in = res_ff;  status_in = status_ff;
      unique case (cmd.op)
         OP_ACCEPT: begin
            x_in = req_x_value;
            if (we) begin
               saved_in = '0;
               corr_in = 1'b0;
            end
         end
         OP_RD_LAST: x0_in = rdx_ff;
         OP_START: begin
            asc_in = rdx_ff >= x0_ff;
            lo_in = '0;
            hi_in = nm1;
         end
         OP_HUNT_DIR: begin
            lo_in = js_w;
            hi_in = js_w;
            inc_in = CW'(1);
         end
         OP_HUP: hi_in = sts.up_end ? nm1 : up_sum;
         OP_HUP_EV: begin
            if (above_w) begin
               lo_in = hi_ff;
               inc_in = inc_ff << 1;
            end
         end
         OP_HDN: lo_in = sts.dn_end ? '0 : dn_dif;
         OP_HDN_EV: begin
            if (!above_w) begin
               hi_in = lo_ff;
               inc_in = inc_ff << 1;
            end
         end
         OP_BIS: mid_in = mid_w;
         OP_BIS_EV: begin
            if (above_w) begin
               lo_in = mid_ff;
            end else begin
               hi_in = mid_ff;
            end
         end
         OP_SEG: begin
            corr_in = js_dist <= CW'(dj_w);
            saved_in = IW'(lo_ff);
            j_in = seg_j;
         end
         OP_RD_J: begin
            xj_in = rdx_ff;
            yj_in = rdy_ff;
         end
         OP_RD_J1: begin
            xj1_in = rdx_ff;
            yj1_in = rdy_ff;
         end
         OP_DIFF: begin
            a_in = dxq33[32] ? -dxq33 : dxq33;
            b_in = dy33[32] ? -dy33 : dy33;
            c_in = dx33[32] ? -dx33 : dx33;
            neg_in = dx33[32] ^ dxq33[32] ^ dy33[32];
            zero_in = sts.zero_w;
            acc_in = '0;
            step_in = '0;
         end
         OP_MUL: begin
            acc_in = acc_ff + pp_sh;
            step_in = step_ff + 6'd1;
         end
         OP_DIV_INIT: begin
            // a quotient of 2^34 or more saturates whatever the low bits are
            big_in = {1'b0, acc_ff[65:34]} >= c_ff;
            rem_in = {2'b00, acc_ff[65:34]};
            p_in = acc_ff[33:0];
            q_in = '0;
            step_in = '0;
         end
         OP_DIV: begin
            rem_in = ge_w ? t_w - {1'b0, c_ff} : t_w;
            q_in = {q_ff[32:0], ge_w};
            p_in = p_ff << 1;
            step_in = step_ff + 6'd1;
         end
         OP_OUT: begin
            if (sts.out_free) begin
               rsp_valid_in = 1'b1;
               status_in = STS_OK;
               if (zero_ff) begin
                  res_in = yj_ff;
               end else if (big_ff || q_ff > 34'h2_0000_0000) begin
                  res_in = neg_ff ? 32'sh8000_0000 : 32'sh7fff_ffff;
                  status_in = STS_SAT;
               end else if (sum36 > 36'sd2147483647) begin
                  res_in = 32'sh7fff_ffff;
                  status_in = STS_SAT;
               end else if (sum36 < -36'sd2147483648) begin
                  res_in = 32'sh8000_0000;
                  status_in = STS_SAT;
               end else begin
                  res_in = sum36[31:0];
               end
            end
         end
         OP_OUT_FEW: begin
            if (sts.out_free) begin
               rsp_valid_in = 1'b1;
               res_in = '0;
               status_in = STS_FEW;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         point_count_ff <= '0;
         saved_ff <= '0;
         corr_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         point_count_ff <= point_count_in;
         saved_ff <= saved_in;
         corr_ff <= corr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;  x0_ff <= x0_in;  asc_ff <= asc_in;
      lo_ff <= lo_in;  hi_ff <= hi_in;  inc_ff <= inc_in;  mid_ff <= mid_in;  j_ff <= j_in;
      xj_ff <= xj_in;  yj_ff <= yj_in;  xj1_ff <= xj1_in;  yj1_ff <= yj1_in;
      a_ff <= a_in;  b_ff <= b_in;  c_ff <= c_in;
      neg_ff <= neg_in;  zero_ff <= zero_in;  big_ff <= big_in;
      acc_ff <= acc_in;  step_ff <= step_in;  rem_ff <= rem_in;  p_ff <= p_in;  q_ff <= q_in;
      res_ff <= res_in;  status_ff <= status_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = res_ff;
   assign rsp_status       = status_ff;

   `TLI_ASSERT_NOW(a_bis_order, clock, reset, cmd.op == OP_BIS, lo_ff <= hi_ff,
      "bisection bounds crossed")
   `TLI_ASSERT_NEXT(a_rem_bound, clock, reset, (cmd.op == OP_DIV) && !big_ff,
      rem_ff < {1'b0, c_ff}, "division remainder not below divisor")
   `TLI_ASSERT_NOW(a_sat_limit, clock, reset, rsp_valid_ff && (status_ff == STS_SAT),
      (res_ff == 32'sh7fff_ffff) || (res_ff == 32'sh8000_0000),
      "saturated status without a limit value")

endmodule

// File: src/table_linear_interpolator.sv
// channel | direction | handshake            | payload
// req     | in        | req_valid/req_stall  | mode, point_index, x_value, y_value
// rsp     | out       | rsp_valid/rsp_stall  | result_value, status
// csr     | in        | csr_valid/csr_ready  | point_count
//
// a load in range is written when accepted and the block stays idle; a query with fewer than two
// points skips the search and returns the few-points status; otherwise each search probe is a
// read on the single table read port followed by an evaluation step, then come 4 multiply steps
// and 34 divide steps in the multiply/divide unit; a zero-width segment skips the arithmetic
// one item is in work at a time; the result register lets the next item start
// while rsp is stalled, and a query waits at its end for that register to free up
// reset is synchronous, active high; clears point count, saved index, hunt flag and response valid
module table_linear_interpolator
   import tli_pkg::*;
#(
   parameter int MAX_POINTS = MAX_POINTS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_mode,
   input  logic        [5:0]  req_point_index,
   input  logic signed [31:0] req_x_value,
   input  logic signed [31:0] req_y_value,
   // response channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_result_value,
   output logic        [1:0]  rsp_status,
   // point count register
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic        [6:0]  csr_point_count
);

   cmd_type cmd;
   sts_type sts;

   // the user must send writes only while idle (the block does not enforce it); the register port never pushes back
   assign csr_ready = 1'b1;

   // sequencer: states for the search probes and their evaluation, and for the multiply and divide steps
   tli_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_mode),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // tables, search bounds, multiply/divide unit and result register
   tli_dpath #(
      .MAX_POINTS (MAX_POINTS)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .csr_we           (csr_valid && csr_ready),
      .csr_point_count  (csr_point_count),
      .req_mode         (req_mode),
      .req_point_index  (req_point_index),
      .req_x_value      (req_x_value),
      .req_y_value      (req_y_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_value (rsp_result_value),
      .rsp_status       (rsp_status)
   );

endmodule
